// ----- rtl/pgse_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgse_pkg
// Shared types, constants and table functions for the Phong specular core.
// ----------------------------------------------------------------------------
package pgse_pkg;

   localparam int CosW    = 38;
   localparam int PowW    = 45;
   localparam int ACapW   = 33;
   localparam int CsrIdxW = 3;

   localparam logic [CsrIdxW-1:0] CsrPhongExponent = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrKsGain        = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrColorRed      = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrColorGreen    = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrColorBlue     = 3'd4;

   localparam logic signed [23:0] LogOffset = 24'(28 * 65536);
   localparam logic [PowW-1:0]    PowCap    = PowW'(1) << 44;
   localparam logic [ACapW-1:0]   ACap      = ACapW'(1) << 32;

   typedef logic [63:0] u64_type;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [15:0] light_x;
      logic signed [15:0] light_y;
      logic signed [15:0] light_z;
      logic signed [15:0] view_x;
      logic signed [15:0] view_y;
      logic signed [15:0] view_z;
   } vec_in_type;

   typedef struct packed {
      logic            valid;
      logic            lobe;
      logic [CosW-1:0] cos;
   } dot_res_type;

   typedef struct packed {
      logic            valid;
      logic            lobe;
      logic [PowW-1:0] pw;
   } pow_res_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] radiance_red;
      logic [15:0] radiance_green;
      logic [15:0] radiance_blue;
      logic        lobe_active;
   } rsp_word_type;

   function automatic u64_type isqrt64(input u64_type a_in);
      u64_type a;
      u64_type res;
      u64_type bit_v;
      a     = a_in;
      res   = '0;
      bit_v = u64_type'(1) << 62;
      for (int i = 0; i < 32; i++) begin
         if (bit_v > a) bit_v = bit_v >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bit_v != '0) begin
            if (a >= res + bit_v) begin
               a   = a - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return res;
   endfunction

   function automatic u64_type log_from_x(input u64_type x_in);
      u64_type x;
      u64_type acc;
      x   = x_in;
      acc = '0;
      for (int i = 0; i < 17; i++) begin
         x   = (x * x) >> 30;
         acc = acc << 1;
         if (x >= (u64_type'(2) << 30)) begin
            x   = x >> 1;
            acc = acc | u64_type'(1);
         end
      end
      return (acc + u64_type'(1)) >> 1;
   endfunction

   function automatic u64_type exp_from_f(input u64_type f);
      u64_type x;
      u64_type r;
      x = u64_type'(1) << 30;
      r = isqrt64(u64_type'(1) << 61);
      for (int i = 1; i <= 20; i++) begin
         if (f[20-i]) x = (x * r) >> 30;
         r = isqrt64(r << 30);
      end
      return (x + (u64_type'(1) << 13)) >> 14;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/pgse_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgse_req_if
// Input word channel: normal, light and view vectors in signed Q1.14.
// ----------------------------------------------------------------------------
interface pgse_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;
   logic signed [15:0] light_x;
   logic signed [15:0] light_y;
   logic signed [15:0] light_z;
   logic signed [15:0] view_x;
   logic signed [15:0] view_y;
   logic signed [15:0] view_z;

   modport source (output valid, normal_x, normal_y, normal_z, light_x, light_y, light_z,
                   view_x, view_y, view_z, input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, light_x, light_y, light_z,
                   view_x, view_y, view_z, output ready);
endinterface
`default_nettype wire

// ----- rtl/pgse_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgse_rsp_if
// Result word channel: saturated Q4.12 radiance and lobe flag.
// ----------------------------------------------------------------------------
interface pgse_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] radiance_red;
   logic [15:0] radiance_green;
   logic [15:0] radiance_blue;
   logic        lobe_active;

   modport source (output valid, radiance_red, radiance_green, radiance_blue, lobe_active,
                   input ready);
   modport sink   (input valid, radiance_red, radiance_green, radiance_blue, lobe_active,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/pgse_csr_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgse_csr_if
// Register write channel: register index and 16-bit write data.
// ----------------------------------------------------------------------------
interface pgse_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/phong_glossy_specular_eval_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// phong_glossy_specular_eval_core
// Phong specular lobe evaluation, one word per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// req_ch carries normal, light and view vectors (signed Q1.14); rsp_ch returns
// red, green and blue radiance (unsigned Q4.12, saturated) and lobe_active.
// csr_ch writes phong_exponent (Q8.8), ks_gain and the three colour channels
// (Q4.12); it is always ready and takes effect for words accepted afterward.
// Write registers only while no word is in flight.
// Pipeline: 3 stages of dot products, 7 stages of log2/exponent/exp2
// (registered table reads), 3 stages of gain and colour scaling.
// Throughput: one word per cycle. All stages advance together whenever the
// output register is empty or being taken; when the receiver stalls, the
// whole pipeline holds and req_ch.ready drops in the same cycle.
// Reset clears every stage's valid bit and loads the register defaults
// (exponent 1.0, gain and colours 1.0).
// ----------------------------------------------------------------------------
module phong_glossy_specular_eval_core #(
   parameter int POW_TABLE_ENTRIES = 256
) (
   input  logic         clock,
   input  logic         reset,
   pgse_req_if.sink     req_ch,
   pgse_rsp_if.source   rsp_ch,
   pgse_csr_if.sink     csr_ch
);
   import pgse_pkg::*;

   logic         en;
   vec_in_type   vin;
   dot_res_type  dot_res;
   pow_res_type  pow_res;
   rsp_word_type rsp_word;

   logic [15:0] phong_exponent_ff, ks_gain_ff, color_red_ff, color_green_ff, color_blue_ff;

   assign en           = !rsp_word.valid || rsp_ch.ready;
   assign req_ch.ready = en;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phong_exponent_ff <= 16'd256;
         ks_gain_ff        <= 16'd4096;
         color_red_ff      <= 16'd4096;
         color_green_ff    <= 16'd4096;
         color_blue_ff     <= 16'd4096;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CsrPhongExponent: phong_exponent_ff <= csr_ch.data;
            CsrKsGain:        ks_gain_ff        <= csr_ch.data;
            CsrColorRed:      color_red_ff      <= csr_ch.data;
            CsrColorGreen:    color_green_ff    <= csr_ch.data;
            CsrColorBlue:     color_blue_ff     <= csr_ch.data;
            default: ;
         endcase
      end
   end

   assign vin.normal_x = req_ch.normal_x;
   assign vin.normal_y = req_ch.normal_y;
   assign vin.normal_z = req_ch.normal_z;
   assign vin.light_x  = req_ch.light_x;
   assign vin.light_y  = req_ch.light_y;
   assign vin.light_z  = req_ch.light_z;
   assign vin.view_x   = req_ch.view_x;
   assign vin.view_y   = req_ch.view_y;
   assign vin.view_z   = req_ch.view_z;

   pgse_dot u_dot (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_ch.valid),
      .vin      (vin),
      .dout     (dot_res)
   );

   pgse_pow #(.POW_TABLE_ENTRIES(POW_TABLE_ENTRIES)) u_pow (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .phong_exponent (phong_exponent_ff),
      .din            (dot_res),
      .dout           (pow_res)
   );

   pgse_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .ks_gain     (ks_gain_ff),
      .color_red   (color_red_ff),
      .color_green (color_green_ff),
      .color_blue  (color_blue_ff),
      .din         (pow_res),
      .dout        (rsp_word)
   );

   assign rsp_ch.valid          = rsp_word.valid;
   assign rsp_ch.radiance_red   = rsp_word.radiance_red;
   assign rsp_ch.radiance_green = rsp_word.radiance_green;
   assign rsp_ch.radiance_blue  = rsp_word.radiance_blue;
   assign rsp_ch.lobe_active    = rsp_word.lobe_active;

endmodule
`default_nettype wire

// ----- rtl/pgse_dot.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgse_dot
// Three-stage dot products and reflected cosine 2(n.l)(n.v) - l.v.
// ----------------------------------------------------------------------------
module pgse_dot (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  pgse_pkg::vec_in_type   vin,
   output pgse_pkg::dot_res_type  dout
);
   import pgse_pkg::*;

   logic signed [33:0] nl_ff, nv_ff, lv_ff, nl_in, nv_in, lv_in;
   logic               v1_ff, v2_ff, v3_ff;
   logic signed [19:0] nl_s, nv_s;
   logic signed [39:0] mul_ff, mul_in;
   logic signed [33:0] lv2_ff;
   logic signed [41:0] c_w;
   logic [CosW-1:0]    cos_ff;
   logic               lobe_ff;

   assign nl_in = 34'(vin.normal_x * vin.light_x) + 34'(vin.normal_y * vin.light_y)
                + 34'(vin.normal_z * vin.light_z);
   assign nv_in = 34'(vin.normal_x * vin.view_x) + 34'(vin.normal_y * vin.view_y)
                + 34'(vin.normal_z * vin.view_z);
   assign lv_in = 34'(vin.light_x * vin.view_x) + 34'(vin.light_y * vin.view_y)
                + 34'(vin.light_z * vin.view_z);

   assign nl_s   = nl_ff[33:14];
   assign nv_s   = nv_ff[33:14];
   assign mul_in = nl_s * nv_s;
   assign c_w    = (42'(mul_ff) <<< 1) - 42'(lv2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nl_ff   <= nl_in;
         nv_ff   <= nv_in;
         lv_ff   <= lv_in;
         mul_ff  <= mul_in;
         lv2_ff  <= lv_ff;
         cos_ff  <= c_w[CosW-1:0];
         lobe_ff <= (c_w > 0);
      end
   end

   assign dout.valid = v3_ff;
   assign dout.lobe  = lobe_ff;
   assign dout.cos   = cos_ff;

endmodule
`default_nettype wire

// ----- rtl/pgse_pow.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgse_pow
// Seven-stage power unit: log2 by table, scale by exponent, exp2 by table.
// ----------------------------------------------------------------------------
module pgse_pow #(
   parameter int POW_TABLE_ENTRIES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic [15:0]            phong_exponent,
   input  pgse_pkg::dot_res_type  din,
   output pgse_pkg::pow_res_type  dout
);
   import pgse_pkg::*;

   localparam int IdxW = $clog2(POW_TABLE_ENTRIES);

   logic [16:0] lt_rom [POW_TABLE_ENTRIES];
   logic [17:0] et_rom [POW_TABLE_ENTRIES];

   for (genvar g = 0; g < POW_TABLE_ENTRIES; g++) begin : g_rom
      localparam u64_type LogX =
         (u64_type'(POW_TABLE_ENTRIES + g) << 30) / POW_TABLE_ENTRIES;
      localparam u64_type ExpF = (u64_type'(g) << 20) / POW_TABLE_ENTRIES;
      assign lt_rom[g] = 17'(log_from_x(LogX));
      assign et_rom[g] = 18'(exp_from_f(ExpF));
   end

   logic [6:0]  v_ff;
   logic [6:0]  lobe_ff;

   logic [5:0]         p_w, p4_ff, p5_ff, p6_ff;
   logic [CosW-1:0]    c4_ff;
   logic [CosW+15:0]   sh_w;
   logic [31:0]        k1_prod;
   logic [IdxW-1:0]    k1_ff;
   logic [16:0]        lt_ff;
   logic signed [23:0] l_w;
   logic signed [40:0] lp_w, lp_ff;
   logic [31:0]        k2_prod;
   logic [IdxW-1:0]    k2_ff;
   logic signed [16:0] q8_ff, q9_ff;
   logic [16:0]        nq_w;
   logic [17:0]        et_ff;
   logic [45:0]        up_w;
   logic [PowW-1:0]    pw_in, pw_ff;

   always_comb begin
      p_w = '0;
      for (int i = 0; i < CosW; i++) begin
         if (din.cos[i]) p_w = 6'(i);
      end
   end

   assign sh_w    = {c4_ff, 16'b0} >> p4_ff;
   assign k1_prod = 32'(sh_w[15:0]) * 32'(POW_TABLE_ENTRIES);
   assign l_w     = $signed({2'b0, p6_ff, 16'b0}) - LogOffset + $signed({7'b0, lt_ff});
   assign lp_w    = l_w * $signed({1'b0, phong_exponent});
   assign k2_prod = 32'(lp_ff[23:8]) * 32'(POW_TABLE_ENTRIES);
   assign nq_w    = -q9_ff;
   assign up_w    = 46'(et_ff) << q9_ff[4:0];

   always_comb begin
      if (q9_ff >= 28) begin
         pw_in = PowCap;
      end else if (q9_ff >= 0) begin
         pw_in = (up_w > 46'(PowCap)) ? PowCap : up_w[PowW-1:0];
      end else if (q9_ff <= -63) begin
         pw_in = '0;
      end else begin
         pw_in = PowW'(et_ff >> nq_w[5:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[5:0], din.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lobe_ff <= {lobe_ff[5:0], din.lobe};
         p4_ff   <= p_w;
         c4_ff   <= din.cos;
         p5_ff   <= p4_ff;
         k1_ff   <= k1_prod[16 +: IdxW];
         p6_ff   <= p5_ff;
         lt_ff   <= lt_rom[k1_ff];
         lp_ff   <= lp_w;
         q8_ff   <= lp_ff[40:24];
         k2_ff   <= k2_prod[16 +: IdxW];
         q9_ff   <= q8_ff;
         et_ff   <= et_rom[k2_ff];
         pw_ff   <= pw_in;
      end
   end

   assign dout.valid = v_ff[6];
   assign dout.lobe  = lobe_ff[6];
   assign dout.pw    = pw_ff;

endmodule
`default_nettype wire

// ----- rtl/pgse_scale.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgse_scale
// Three-stage gain and colour scaling with saturation to Q4.12.
// ----------------------------------------------------------------------------
module pgse_scale (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic [15:0]            ks_gain,
   input  logic [15:0]            color_red,
   input  logic [15:0]            color_green,
   input  logic [15:0]            color_blue,
   input  pgse_pkg::pow_res_type  din,
   output pgse_pkg::rsp_word_type dout
);
   import pgse_pkg::*;

   logic [2:0]       v_ff;
   logic [1:0]       lobe_ff;
   logic [38:0]      pl_ff;
   logic [37:0]      ph_ff;
   logic [60:0]      sum_w;
   logic [ACapW-1:0] a_in, a_ff;
   logic [48:0]      mr_w, mg_w, mb_w;
   logic [15:0]      r_ff, g_ff, b_ff;
   logic             la_ff;

   function automatic logic [15:0] sat16(input logic [48:0] m);
      return (|m[48:32]) ? 16'hFFFF : m[31:16];
   endfunction

   assign sum_w = (61'(ph_ff) << 23) + 61'(pl_ff);
   assign a_in  = (sum_w[60:12] > 49'(ACap)) ? ACap : sum_w[12 +: ACapW];
   assign mr_w  = 49'(a_ff) * 49'(color_red);
   assign mg_w  = 49'(a_ff) * 49'(color_green);
   assign mb_w  = 49'(a_ff) * 49'(color_blue);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[1:0], din.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lobe_ff <= {lobe_ff[0], din.lobe};
         pl_ff   <= 39'(din.pw[22:0]) * 39'(ks_gain);
         ph_ff   <= 38'(din.pw[44:23]) * 38'(ks_gain);
         a_ff    <= a_in;
         r_ff    <= lobe_ff[1] ? sat16(mr_w) : 16'h0;
         g_ff    <= lobe_ff[1] ? sat16(mg_w) : 16'h0;
         b_ff    <= lobe_ff[1] ? sat16(mb_w) : 16'h0;
         la_ff   <= lobe_ff[1];
      end
   end

   assign dout.valid          = v_ff[2];
   assign dout.radiance_red   = r_ff;
   assign dout.radiance_green = g_ff;
   assign dout.radiance_blue  = b_ff;
   assign dout.lobe_active    = la_ff;

endmodule
`default_nettype wire

// ----- rtl/pgse_sva.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pgse_sva
// Port-level checks for the Phong specular core, bound to the top level.
// ----------------------------------------------------------------------------
module pgse_sva (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] radiance_red,
   input logic [15:0] radiance_green,
   input logic [15:0] radiance_blue,
   input logic        lobe_active
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output stall");

   a_black_off_lobe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !lobe_active) |->
      (radiance_red == 16'h0 && radiance_green == 16'h0 && radiance_blue == 16'h0))
      else $error("nonzero radiance outside lobe");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped while stalled");

   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      ($stable(radiance_red) && $stable(radiance_green) && $stable(radiance_blue)
       && $stable(lobe_active)))
      else $error("result changed while stalled");

endmodule

bind phong_glossy_specular_eval_core pgse_sva u_pgse_sva (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .radiance_red   (rsp_ch.radiance_red),
   .radiance_green (rsp_ch.radiance_green),
   .radiance_blue  (rsp_ch.radiance_blue),
   .lobe_active    (rsp_ch.lobe_active)
);
`default_nettype wire
